[rtl/vertex_normal_accumulator_macros.svh]
// assertion macros for the vertex normal accumulator
// used by the rtl files that carry concurrent checks
`ifndef VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH
`define VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define VNA_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define VNA_ASSERT_NEXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define VNA_ASSERT(name, clk, rst, prop)
`define VNA_ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

[rtl/vna_pkg.sv]
// shared constants, types and helpers for the vertex normal accumulator
// no dependencies
package vna_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int COUNT_W      = 13;
  localparam int POS_W        = 32;
  localparam int NRM_W        = 16;
  localparam int SUM_W        = 24;
  localparam int VEC_W        = 65;
  localparam int MAG_W        = 64;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_TRI   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [PADDR_W-1:0] ADDR_VERTEX_COUNT = '0;
  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = COUNT_W'(MAX_VERTICES);

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [NRM_W-1:0] nrm_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [VEC_W-1:0] vec_t;

  // saturating add of a unit component onto a running sum
  function automatic sum_t sat_sum(input sum_t s, input nrm_t u);
    logic signed [SUM_W:0] t;
    t = {s[SUM_W-1], s} + {{(SUM_W-NRM_W+1){u[NRM_W-1]}}, u};
    if (t[SUM_W] != t[SUM_W-1]) begin
      return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return t[SUM_W-1:0];
  endfunction

endpackage

[rtl/vna_if.sv]
// request and response channel interfaces
// depends on vna_pkg
interface vna_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  vna_pkg::idx_t     vertex_index;
  vna_pkg::pos_t     pos_x;
  vna_pkg::pos_t     pos_y;
  vna_pkg::pos_t     pos_z;
  vna_pkg::idx_t     corner_a;
  vna_pkg::idx_t     corner_b;
  vna_pkg::idx_t     corner_c;
  modport source (output valid, req_type, vertex_index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink (input valid, req_type, vertex_index, pos_x, pos_y, pos_z,
                corner_a, corner_b, corner_c, output ready);
endinterface

interface vna_rsp_if;
  logic          valid;
  logic          ready;
  vna_pkg::nrm_t normal_x;
  vna_pkg::nrm_t normal_y;
  vna_pkg::nrm_t normal_z;
  vna_pkg::idx_t normal_vertex;
  modport source (output valid, normal_x, normal_y, normal_z, normal_vertex,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, normal_vertex,
                output ready);
endinterface

[rtl/vna_ram.sv]
// generic single write port ram with registered read
// no dependencies
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/vna_norm.sv]
// iterative normaliser: scale, sum of squares, bitwise square root,
// then restoring division per component; depends on vna_pkg
module vna_norm (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  vna_pkg::vec_t vin [3],
  output logic          done,
  output vna_pkg::nrm_t vout [3]
);

  localparam int SQ_W      = 50;
  localparam int RT_W      = 51;
  localparam int LEN_W     = 25;
  localparam int NUM_W     = 40;
  localparam int Q_W       = 17;
  localparam logic [4:0] DIV_STEPS = 5'd17;

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_SCALE = 6'b000010,
    N_SQ    = 6'b000100,
    N_SQRT  = 6'b001000,
    N_DIV   = 6'b010000,
    N_DONE  = 6'b100000
  } nstate_t;

  nstate_t                   state;
  logic                      neg [3];
  logic [vna_pkg::MAG_W-1:0] mag [3];
  logic [vna_pkg::MAG_W-1:0] vabs [3];
  logic [vna_pkg::MAG_W-1:0] orv;
  logic [1:0]                cnt;
  logic [1:0]                sq_idx;
  logic [47:0]               sq_p;
  logic [SQ_W-1:0]           sq;
  logic [SQ_W-1:0]           sq_n;
  logic [RT_W-1:0]           root;
  logic [RT_W-1:0]           root_next;
  logic [RT_W-1:0]           bitv;
  logic [RT_W:0]             t_root;
  logic                      rt_ge;
  logic [LEN_W-1:0]          len;
  logic [1:0]                ci;
  logic [4:0]                dcnt;
  logic [LEN_W-1:0]          drem;
  logic [Q_W-1:0]            dlow;
  logic [Q_W-1:0]            dq;
  logic [Q_W-1:0]            q_next;
  logic [NUM_W-1:0]          numer;
  logic [LEN_W:0]            div_t;
  logic [LEN_W:0]            div_r;
  logic                      div_ge;
  vna_pkg::nrm_t             q_sat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vabs[i] = vin[i][vna_pkg::VEC_W-1] ? vna_pkg::MAG_W'(-vin[i])
                                         : vna_pkg::MAG_W'(vin[i]);
    end
    orv       = mag[0] | mag[1] | mag[2];
    sq_idx    = (cnt == 2'd3) ? 2'd0 : cnt;
    t_root    = {1'b0, root} + {1'b0, bitv};
    rt_ge     = {2'b00, sq_n} >= t_root;
    root_next = rt_ge ? (root >> 1) + bitv : root >> 1;
    numer     = {1'b0, mag[ci][23:0], 15'd0} + {16'd0, len[LEN_W-1:1]};
    div_t     = {drem, dlow[Q_W-1]};
    div_ge    = div_t >= {1'b0, len};
    div_r     = div_ge ? div_t - {1'b0, len} : div_t;
    q_next    = {dq[Q_W-2:0], div_ge};
    if (neg[ci]) begin
      q_sat = (q_next >= 17'd32768) ? 16'sh8000 : -$signed(q_next[15:0]);
    end else begin
      q_sat = (q_next > 17'd32767) ? 16'sh7fff : $signed(q_next[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      case (state)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= vabs[i];
              neg[i] <= vin[i][vna_pkg::VEC_W-1];
            end
            state <= N_SCALE;
          end
        end
        N_SCALE: begin
          if (orv == '0) begin
            for (int i = 0; i < 3; i++) vout[i] <= '0;
            state <= N_DONE;
          end else if (|orv[63:32]) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 8;
          end else if (|orv[31:24]) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (orv[23:15] == '0) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 8;
          end else if (!orv[23]) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            cnt   <= 2'd0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          sq_p <= mag[sq_idx][23:0] * mag[sq_idx][23:0];
          sq   <= (cnt == 2'd0) ? '0 : sq + {2'b00, sq_p};
          cnt  <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            sq_n  <= sq + {2'b00, sq_p};
            root  <= '0;
            bitv  <= {1'b1, {(RT_W-1){1'b0}}};
            state <= N_SQRT;
          end
        end
        N_SQRT: begin
          if (rt_ge) begin
            sq_n <= sq_n - t_root[SQ_W-1:0];
          end
          root <= root_next;
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            len   <= root_next[LEN_W-1:0];
            ci    <= 2'd0;
            dcnt  <= '0;
            state <= N_DIV;
          end
        end
        N_DIV: begin
          if (dcnt == '0) begin
            drem <= {2'b00, numer[NUM_W-1:Q_W]};
            dlow <= numer[Q_W-1:0];
            dq   <= '0;
            dcnt <= 5'd1;
          end else begin
            drem <= div_r[LEN_W-1:0];
            dlow <= dlow << 1;
            dq   <= q_next;
            if (dcnt == DIV_STEPS) begin
              vout[ci] <= q_sat;
              dcnt     <= '0;
              if (ci == 2'd2) begin
                state <= N_DONE;
              end else begin
                ci <= ci + 2'd1;
              end
            end else begin
              dcnt <= dcnt + 5'd1;
            end
          end
        end
        N_DONE: begin
          state <= N_IDLE;
        end
        default: begin
          state <= N_IDLE;
        end
      endcase
    end
  end

  assign done = (state == N_DONE);

endmodule

[rtl/vertex_normal_accumulator.sv]
// vertex normal accumulator: position and normal-sum stores, cross product
// on one shared 32x32 multiplier, normalisation in vna_norm
// reads and triangles pass through the normaliser's square root (26 steps)
// and three restoring divisions, one per component
// one request at a time; req.ready is low until the current one finishes
// rst is synchronous and clears control state and vertex_count (to 4096)
// depends on vna_pkg, vna_if, vna_ram, vna_norm and the assertion macros
`include "vertex_normal_accumulator_macros.svh"

module vertex_normal_accumulator (
  input  logic                          clk,
  input  logic                          rst,
  vna_req_if.sink                       req,
  vna_rsp_if.source                     rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vna_pkg::PADDR_W-1:0]   paddr,
  input  logic [vna_pkg::PDATA_W-1:0]   pwdata,
  output logic [vna_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int PW = 3 * vna_pkg::POS_W;
  localparam int SW = 3 * vna_pkg::SUM_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WRITE = 9'b000000010,
    S_RDPOS = 9'b000000100,
    S_EDGE  = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_NORM  = 9'b000100000,
    S_SUM   = 9'b001000000,
    S_RDSUM = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t                        state;
  logic [vna_pkg::COUNT_W-1:0]   vertex_count;
  logic [2:0]                    cnt;
  logic [2:0]                    jdx;
  logic                          is_read;
  vna_pkg::idx_t                 r_idx;
  vna_pkg::pos_t                 r_x, r_y, r_z;
  vna_pkg::idx_t                 corner [3];
  logic [PW-1:0]                 pos [3];
  vna_pkg::pos_t                 e1 [3];
  vna_pkg::pos_t                 e2 [3];
  vna_pkg::pos_t                 e1_next [3];
  vna_pkg::pos_t                 e2_next [3];
  logic signed [32:0]            d1 [3];
  logic signed [32:0]            d2 [3];
  logic signed [32:0]            h1 [3];
  logic signed [32:0]            h2 [3];
  logic                          big;
  vna_pkg::pos_t                 mul_a, mul_b;
  logic signed [63:0]            prod;
  logic signed [63:0]            first;
  vna_pkg::vec_t                 nvec [3];
  logic                          norm_go;
  logic                          norm_done;
  vna_pkg::nrm_t                 unit [3];
  logic                          in_range;
  logic                          cfg_wr;
  logic [1:0]                    csel;
  logic [1:0]                    psel_idx;

  logic                          pos_we;
  vna_pkg::idx_t                 pos_raddr;
  logic [PW-1:0]                 pos_rdata;
  logic                          sum_we;
  vna_pkg::idx_t                 sum_waddr;
  vna_pkg::idx_t                 sum_raddr;
  logic [SW-1:0]                 sum_wdata;
  logic [SW-1:0]                 sum_rdata;

  vna_ram #(.WIDTH(PW), .DEPTH(vna_pkg::MAX_VERTICES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (r_idx),
    .wdata ({r_x, r_y, r_z}),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  vna_ram #(.WIDTH(SW), .DEPTH(vna_pkg::MAX_VERTICES)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  vna_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_go),
    .vin   (nvec),
    .done  (norm_done),
    .vout  (unit)
  );

  // apb register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == vna_pkg::ADDR_VERTEX_COUNT);
  assign prdata = (paddr == vna_pkg::ADDR_VERTEX_COUNT)
                ? {{(vna_pkg::PDATA_W-vna_pkg::COUNT_W){1'b0}}, vertex_count} : '0;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign in_range  = ({1'b0, req.corner_a} < vertex_count)
                  && ({1'b0, req.corner_b} < vertex_count)
                  && ({1'b0, req.corner_c} < vertex_count);

  // edge differences with common halving when any has magnitude 2^31 or more
  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d1[i] = {pos[1][(2-i)*32+31], pos[1][(2-i)*32 +: 32]}
            - {pos[0][(2-i)*32+31], pos[0][(2-i)*32 +: 32]};
      d2[i] = {pos[2][(2-i)*32+31], pos[2][(2-i)*32 +: 32]}
            - {pos[0][(2-i)*32+31], pos[0][(2-i)*32 +: 32]};
      h1[i] = $signed(d1[i] + {32'd0, d1[i][32]}) >>> 1;
      h2[i] = $signed(d2[i] + {32'd0, d2[i][32]}) >>> 1;
      if ((d1[i][32] != d1[i][31]) || (d1[i][32:31] == 2'b11 && d1[i][30:0] == '0)
          || (d2[i][32] != d2[i][31])
          || (d2[i][32:31] == 2'b11 && d2[i][30:0] == '0)) begin
        big = 1'b1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      e1_next[i] = big ? h1[i][31:0] : d1[i][31:0];
      e2_next[i] = big ? h2[i][31:0] : d2[i][31:0];
    end
  end

  // cross product operand order
  always_comb begin
    case (cnt)
      3'd0: begin mul_a = e1[1]; mul_b = e2[2]; end
      3'd1: begin mul_a = e1[2]; mul_b = e2[1]; end
      3'd2: begin mul_a = e1[2]; mul_b = e2[0]; end
      3'd3: begin mul_a = e1[0]; mul_b = e2[2]; end
      3'd4: begin mul_a = e1[0]; mul_b = e2[1]; end
      3'd5: begin mul_a = e1[1]; mul_b = e2[0]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    jdx       = cnt - 3'd1;
    psel_idx  = (cnt[1:0] == 2'd3) ? 2'd0 : cnt[1:0];
    csel      = (cnt[2:1] == 2'd3) ? 2'd0 : cnt[2:1];
    pos_we    = (state == S_WRITE);
    pos_raddr = corner[psel_idx];
    sum_raddr = (state == S_RDSUM) ? r_idx : corner[csel];
    if (state == S_WRITE) begin
      sum_we    = 1'b1;
      sum_waddr = r_idx;
      sum_wdata = '0;
    end else begin
      sum_we    = (state == S_SUM) && cnt[0];
      sum_waddr = corner[csel];
      sum_wdata = {vna_pkg::sat_sum(sum_rdata[2*vna_pkg::SUM_W +: vna_pkg::SUM_W], unit[0]),
                   vna_pkg::sat_sum(sum_rdata[vna_pkg::SUM_W +: vna_pkg::SUM_W], unit[1]),
                   vna_pkg::sat_sum(sum_rdata[0 +: vna_pkg::SUM_W], unit[2])};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= vna_pkg::VERTEX_COUNT_RESET;
      norm_go      <= 1'b0;
    end else begin
      norm_go <= 1'b0;
      if (cfg_wr) begin
        vertex_count <= pwdata[vna_pkg::COUNT_W-1:0];
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            r_idx     <= req.vertex_index;
            r_x       <= req.pos_x;
            r_y       <= req.pos_y;
            r_z       <= req.pos_z;
            corner[0] <= req.corner_a;
            corner[1] <= req.corner_b;
            corner[2] <= req.corner_c;
            is_read   <= (req.req_type == vna_pkg::REQ_READ);
            cnt       <= '0;
            case (req.req_type)
              vna_pkg::REQ_WRITE: state <= S_WRITE;
              vna_pkg::REQ_TRI:   state <= in_range ? S_RDPOS : S_IDLE;
              vna_pkg::REQ_READ:  state <= S_RDSUM;
              default:            state <= S_IDLE;
            endcase
          end
        end
        S_WRITE: begin
          state <= S_IDLE;
        end
        S_RDPOS: begin
          cnt <= cnt + 3'd1;
          if (cnt != 3'd0) begin
            pos[jdx[1:0]] <= pos_rdata;
          end
          if (cnt == 3'd3) begin
            state <= S_EDGE;
          end
        end
        S_EDGE: begin
          e1    <= e1_next;
          e2    <= e2_next;
          cnt   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= mul_a * mul_b;
          cnt  <= cnt + 3'd1;
          if (cnt != 3'd0) begin
            if (!jdx[0]) begin
              first <= prod;
            end else begin
              nvec[jdx[2:1]] <= {first[63], first} - {prod[63], prod};
            end
          end
          if (cnt == 3'd6) begin
            norm_go <= 1'b1;
            state   <= S_NORM;
          end
        end
        S_NORM: begin
          if (norm_done) begin
            cnt <= '0;
            if (is_read) begin
              rsp.normal_x      <= unit[0];
              rsp.normal_y      <= unit[1];
              rsp.normal_z      <= unit[2];
              rsp.normal_vertex <= r_idx;
              state             <= S_OUT;
            end else begin
              state <= S_SUM;
            end
          end
        end
        S_SUM: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd5) begin
            state <= S_IDLE;
          end
        end
        S_RDSUM: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd1) begin
            for (int i = 0; i < 3; i++) begin
              nvec[i] <= vna_pkg::VEC_W'($signed(sum_rdata[(2-i)*vna_pkg::SUM_W +:
                                                           vna_pkg::SUM_W]));
            end
            norm_go <= 1'b1;
            state   <= S_NORM;
          end
        end
        S_OUT: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `VNA_ASSERT(a_norm_done_waited, clk, rst, norm_done |-> (state == S_NORM))
  `VNA_ASSERT(a_sum_write_odd, clk, rst, (sum_we && state != S_WRITE) |-> cnt[0])
  `VNA_ASSERT_NEXT(a_out_then_idle, clk, rst, rsp.valid && rsp.ready, req.ready)
  `VNA_ASSERT_NEXT(a_bad_tri_dropped, clk, rst,
    req.valid && req.ready && req.req_type == vna_pkg::REQ_TRI && !in_range, req.ready)

endmodule

[test/testbench.sv]
// testbench for vertex_normal_accumulator: drives requests, apb writes and response stalls,
// predicts every normal read with its own integer model held in a small scoreboard class
// depends on vna_pkg, vna_if and the rtl of the block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]    kind;
    vna_pkg::idx_t vidx;
    vna_pkg::pos_t px, py, pz;
    vna_pkg::idx_t ca, cb, cc;
  } request_t;

  typedef struct {
    vna_pkg::nrm_t nx, ny, nz;
    vna_pkg::idx_t vtx;
  } normal_t;

  class normal_scoreboard;
    int      vcount;
    int      pos_mem [vna_pkg::MAX_VERTICES][3];
    int      sum_mem [vna_pkg::MAX_VERTICES][3];
    normal_t pending_q[$];
    int      errors;
    int      checked;

    function new();
      vcount  = vna_pkg::MAX_VERTICES;
      errors  = 0;
      checked = 0;
      for (int i = 0; i < vna_pkg::MAX_VERTICES; i++) begin
        for (int k = 0; k < 3; k++) begin
          pos_mem[i][k] = 0;
          sum_mem[i][k] = 0;
        end
      end
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function automatic void to_unit(input longint v[3], output vna_pkg::nrm_t u[3]);
      longint unsigned m[3], mx, len, q;
      longint s;
      for (int i = 0; i < 3; i++) m[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
      if ((m[0] | m[1] | m[2]) == 0) begin
        for (int i = 0; i < 3; i++) u[i] = '0;
        return;
      end
      forever begin
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        if (mx >= (64'd1 << 24)) begin
          for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end else if (mx < (64'd1 << 23)) begin
          for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end else begin
          break;
        end
      end
      len = root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) begin
        q = (m[i] * 32768 + (len >> 1)) / len;
        if (v[i] < 0) begin
          s = -longint'(q);
          if (s < -32768) s = -32768;
        end else begin
          s = longint'(q);
          if (s > 32767) s = 32767;
        end
        u[i] = vna_pkg::nrm_t'(s);
      end
    endfunction

    function automatic longint halve(longint v);
      return (v < 0) ? -((-v) >>> 1) : (v >>> 1);
    endfunction

    function automatic void add_face(int a, int b, int c);
      longint e1[3], e2[3], n[3], t;
      vna_pkg::nrm_t u[3];
      int corner[3];
      bit big;
      big = 0;
      corner[0] = a;
      corner[1] = b;
      corner[2] = c;
      for (int i = 0; i < 3; i++) begin
        e1[i] = longint'(pos_mem[b][i]) - longint'(pos_mem[a][i]);
        e2[i] = longint'(pos_mem[c][i]) - longint'(pos_mem[a][i]);
        if (e1[i] >= 64'sd2147483648 || e1[i] <= -64'sd2147483648 ||
            e2[i] >= 64'sd2147483648 || e2[i] <= -64'sd2147483648) big = 1;
      end
      if (big) begin
        for (int i = 0; i < 3; i++) begin
          e1[i] = halve(e1[i]);
          e2[i] = halve(e2[i]);
        end
      end
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      to_unit(n, u);
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          t = longint'(sum_mem[corner[k]][i]) + longint'(u[i]);
          if (t > 8388607) t = 8388607;
          if (t < -8388608) t = -8388608;
          sum_mem[corner[k]][i] = int'(t);
        end
      end
    endfunction

    function automatic void note_request(request_t r);
      longint s[3];
      vna_pkg::nrm_t u[3];
      normal_t e;
      case (r.kind)
        vna_pkg::REQ_WRITE: begin
          pos_mem[r.vidx][0] = r.px;
          pos_mem[r.vidx][1] = r.py;
          pos_mem[r.vidx][2] = r.pz;
          for (int i = 0; i < 3; i++) sum_mem[r.vidx][i] = 0;
        end
        vna_pkg::REQ_TRI: begin
          if (r.ca < vcount && r.cb < vcount && r.cc < vcount)
            add_face(int'(r.ca), int'(r.cb), int'(r.cc));
        end
        vna_pkg::REQ_READ: begin
          for (int i = 0; i < 3; i++) s[i] = longint'(sum_mem[r.vidx][i]);
          to_unit(s, u);
          e.nx  = u[0];
          e.ny  = u[1];
          e.nz  = u[2];
          e.vtx = r.vidx;
          pending_q.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function automatic void check_result(normal_t got);
      normal_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected response transaction for vertex %0d", got.vtx);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (got.vtx !== e.vtx) begin
        $error("normal_vertex: expected %0d actual %0d", e.vtx, got.vtx);
        errors++;
      end
      if (got.nx !== e.nx) begin
        $error("normal_x: expected %0d actual %0d", e.nx, got.nx);
        errors++;
      end
      if (got.ny !== e.ny) begin
        $error("normal_y: expected %0d actual %0d", e.ny, got.ny);
        errors++;
      end
      if (got.nz !== e.nz) begin
        $error("normal_z: expected %0d actual %0d", e.nz, got.nz);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [vna_pkg::PADDR_W-1:0] paddr;
  logic [vna_pkg::PDATA_W-1:0] pwdata;
  logic [vna_pkg::PDATA_W-1:0] prdata;
  logic pready;

  vna_req_if req ();
  vna_rsp_if rsp ();

  vertex_normal_accumulator u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req.sink),
    .rsp     (rsp.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  normal_scoreboard sb;
  bit            written [vna_pkg::MAX_VERTICES];
  vna_pkg::idx_t written_q[$];
  bit            no_idle;
  bit            hold_req;
  int            n_write, n_tri, n_read, n_other;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // response side: random stalls, plus one long hold-off on request
  initial begin
    int hold_cnt;
    normal_t got;
    hold_cnt = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        got.nx  = rsp.normal_x;
        got.ny  = rsp.normal_y;
        got.nz  = rsp.normal_z;
        got.vtx = rsp.normal_vertex;
        sb.check_result(got);
      end
      if (hold_req) begin
        hold_cnt = 400;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= no_idle || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  task automatic apb_write(logic [vna_pkg::PADDR_W-1:0] addr,
                           logic [vna_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_vertex_count(int vc);
    req.valid <= 1'b0;
    wait_drained();
    apb_write(vna_pkg::ADDR_VERTEX_COUNT, vna_pkg::PDATA_W'(vc));
    sb.vcount = vc;
  endtask

  // offers one transaction and waits for it to be taken
  task automatic send(request_t r);
    req.valid        <= 1'b1;
    req.req_type     <= r.kind;
    req.vertex_index <= r.vidx;
    req.pos_x        <= r.px;
    req.pos_y        <= r.py;
    req.pos_z        <= r.pz;
    req.corner_a     <= r.ca;
    req.corner_b     <= r.cb;
    req.corner_c     <= r.cc;
    do @(posedge clk); while (!req.ready);
    sb.note_request(r);
    case (r.kind)
      vna_pkg::REQ_WRITE: n_write++;
      vna_pkg::REQ_TRI:   n_tri++;
      vna_pkg::REQ_READ:  n_read++;
      default:            n_other++;
    endcase
    if (!no_idle && $urandom_range(0, 99) < 26) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic request_t noise();
    request_t r;
    r.kind = 2'($urandom);
    r.vidx = vna_pkg::idx_t'($urandom);
    r.px   = $urandom;
    r.py   = $urandom;
    r.pz   = $urandom;
    r.ca   = vna_pkg::idx_t'($urandom);
    r.cb   = vna_pkg::idx_t'($urandom);
    r.cc   = vna_pkg::idx_t'($urandom);
    return r;
  endfunction

  function automatic vna_pkg::pos_t rand_pos();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return vna_pkg::pos_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    if (sel < 9) return $urandom;
    return sel[0] ? 32'sh7fff_ffff : 32'sh8000_0000;
  endfunction

  task automatic send_write(int idx, vna_pkg::pos_t x, vna_pkg::pos_t y, vna_pkg::pos_t z);
    request_t r;
    r = noise();
    r.kind = vna_pkg::REQ_WRITE;
    r.vidx = vna_pkg::idx_t'(idx);
    r.px = x;
    r.py = y;
    r.pz = z;
    if (!written[idx]) written_q.push_back(vna_pkg::idx_t'(idx));
    written[idx] = 1;
    send(r);
  endtask

  task automatic send_tri(int a, int b, int c);
    request_t r;
    r = noise();
    r.kind = vna_pkg::REQ_TRI;
    r.ca = vna_pkg::idx_t'(a);
    r.cb = vna_pkg::idx_t'(b);
    r.cc = vna_pkg::idx_t'(c);
    send(r);
  endtask

  task automatic send_read(int idx);
    request_t r;
    r = noise();
    r.kind = vna_pkg::REQ_READ;
    r.vidx = vna_pkg::idx_t'(idx);
    send(r);
  endtask

  function automatic int pick_below(int vc);
    vna_pkg::idx_t v;
    for (int t = 0; t < 16; t++) begin
      v = written_q[$urandom_range(0, written_q.size() - 1)];
      if (v < vc) return int'(v);
    end
    return -1;
  endfunction

  task automatic random_item(int vc);
    int unsigned sel;
    int a, b, c, lim;
    request_t r;
    sel = $urandom_range(0, 99);
    lim = (vc < 48) ? vc : 48;
    a = pick_below(vc);
    b = pick_below(vc);
    c = pick_below(vc);
    if (sel < 25 || a < 0 || b < 0 || c < 0) begin
      send_write(($urandom_range(0, 9) == 0) ? $urandom_range(0, vna_pkg::MAX_VERTICES - 1)
                                             : $urandom_range(0, lim - 1),
                 rand_pos(), rand_pos(), rand_pos());
    end else if (sel < 65) begin
      if (vc < vna_pkg::MAX_VERTICES && $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: a = $urandom_range(vc, vna_pkg::MAX_VERTICES - 1);
          1: b = $urandom_range(vc, vna_pkg::MAX_VERTICES - 1);
          default: c = $urandom_range(vc, vna_pkg::MAX_VERTICES - 1);
        endcase
      end
      send_tri(a, b, c);
    end else if (sel < 92) begin
      send_read(int'(written_q[$urandom_range(0, written_q.size() - 1)]));
    end else begin
      r = noise();
      r.kind = REQ_UNUSED;
      send(r);
    end
  endtask

  initial begin
    int vc;
    int phase_vc[6];
    sb = new();
    n_write = 0;
    n_tri = 0;
    n_read = 0;
    n_other = 0;
    no_idle = 0;
    hold_req = 0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req.valid <= 1'b0;
    req.req_type <= vna_pkg::REQ_WRITE;
    req.vertex_index <= '0;
    req.pos_x <= '0;
    req.pos_y <= '0;
    req.pos_z <= '0;
    req.corner_a <= '0;
    req.corner_b <= '0;
    req.corner_c <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: unit triangle, degenerate, extreme edges, corner out of range
    send_write(0, 0, 0, 0);
    send_write(1, 32'sh0001_0000, 0, 0);
    send_write(2, 0, 32'sh0001_0000, 0);
    send_write(3, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
    send_write(4095, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    send_read(0);
    send_tri(0, 1, 2);
    send_tri(0, 0, 1);
    send_tri(3, 4095, 0);
    send_tri(1, 2, 4095);
    send_read(0);
    send_read(1);
    send_read(3);
    send_read(4095);
    send_write(1, 32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000);
    send_read(1);
    send_tri(1, 1, 1);
    send_read(2);
    begin
      request_t r;
      r = noise();
      r.kind = REQ_UNUSED;
      send(r);
    end
    set_vertex_count(3);
    send_tri(0, 1, 3);
    send_tri(4095, 2, 1);
    send_tri(0, 1, 2);
    send_read(2);

    // saturation of a hot vertex through a fan of equal faces
    set_vertex_count(vna_pkg::MAX_VERTICES);
    send_write(5, 0, 0, 0);
    send_write(6, 32'sh0002_0000, 0, 0);
    send_write(7, 0, 0, 32'sh0002_0000);
    no_idle = 1;
    repeat (270) send_tri(5, 6, 7);
    send_read(5);
    send_read(7);
    no_idle = 0;

    phase_vc[0] = 1;
    phase_vc[1] = 2;
    phase_vc[2] = 17;
    phase_vc[3] = vna_pkg::MAX_VERTICES;
    phase_vc[4] = $urandom_range(4, 64);
    phase_vc[5] = vna_pkg::MAX_VERTICES;
    for (int p = 0; p < 6; p++) begin
      vc = phase_vc[p];
      set_vertex_count(vc);
      if (p == 3) hold_req = 1;
      if (p == 5) no_idle = 1;
      repeat (130) random_item(vc);
      no_idle = 0;
      if (p == 2) begin
        req.valid <= 1'b0;
        do @(posedge clk); while (sb.pending_q.size() != 0);
      end
    end

    req.valid <= 1'b0;
    wait_drained();
    $display("covered %0d writes, %0d triangles, %0d reads, %0d ignored codes",
             n_write, n_tri, n_read, n_other);
    $display("%0d normals checked over vertex counts from 1 to %0d", sb.checked,
             vna_pkg::MAX_VERTICES);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/vna_pkg.sv
rtl/vna_if.sv
rtl/vna_ram.sv
rtl/vna_norm.sv
rtl/vertex_normal_accumulator.sv
test/testbench.sv
